// ----- src/cbst_pkg.sv -----
// cbst_pkg: shared types and constants of the cbor stream tokenizer
// used by the top level, the nesting stack and the port checker
`default_nettype none

package cbst_pkg;

  localparam int CBST_MAX_DEPTH = 16;

  // token kinds on the result channel
  localparam logic [3:0] K_UINT    = 4'd0;
  localparam logic [3:0] K_NINT    = 4'd1;
  localparam logic [3:0] K_BYTES   = 4'd2;
  localparam logic [3:0] K_TEXT    = 4'd3;
  localparam logic [3:0] K_ARRAY   = 4'd4;
  localparam logic [3:0] K_MAP     = 4'd5;
  localparam logic [3:0] K_FALSE   = 4'd6;
  localparam logic [3:0] K_TRUE    = 4'd7;
  localparam logic [3:0] K_NULL    = 4'd8;
  localparam logic [3:0] K_DOUBLE  = 4'd9;
  localparam logic [3:0] K_PAYLOAD = 4'd10;
  localparam logic [3:0] K_UNSUP   = 4'd11;

  // major types
  localparam logic [2:0] MAJ_UINT   = 3'd0;
  localparam logic [2:0] MAJ_NINT   = 3'd1;
  localparam logic [2:0] MAJ_BYTES  = 3'd2;
  localparam logic [2:0] MAJ_TEXT   = 3'd3;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_TAG    = 3'd6;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  // additional info bounds
  localparam logic [4:0] AI_ONE_BYTE = 5'd24;
  localparam logic [4:0] AI_RESERVED = 5'd28;

  // special head bytes
  localparam logic [7:0] B_FALSE  = 8'hF4;
  localparam logic [7:0] B_TRUE   = 8'hF5;
  localparam logic [7:0] B_NULL   = 8'hF6;
  localparam logic [7:0] B_DOUBLE = 8'hFB;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'b001,
    PH_ARG     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // request from the decoder to the nesting stack
  typedef struct packed {
    logic        fin;    // one item at the current level is complete
    logic        push;   // open a new level
    logic        clear;  // drop every level
    logic [31:0] count;  // items of the new level
  } stk_cmd_t;

  typedef struct packed {
    logic done;  // the finished item closes a top-level item
    logic full;  // no room for another level
  } stk_stat_t;

endpackage

`default_nettype wire

// ----- src/cbst_nest_stack.sv -----
// cbst_nest_stack: nesting stack of items still to come per open level
// counts of lower levels sit in a one-port memory, the top count in a register
// depends on cbst_pkg
`default_nettype none

module cbst_nest_stack #(
  parameter int MAX_DEPTH = cbst_pkg::CBST_MAX_DEPTH,
  parameter int SPW = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cbst_pkg::stk_cmd_t  cmd,
  output      cbst_pkg::stk_stat_t stat,
  output      logic [SPW-1:0]      sp
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [31:0]          mem [MAX_DEPTH];
  logic [31:0]          rd_r;
  logic [31:0]          tos_r, tos_nxt;
  logic                 from_mem_r, from_mem_nxt;
  logic [SPW-1:0]       sp_r, sp_nxt;
  logic [MAX_DEPTH-1:0] one_r, one_nxt;

  logic [31:0]    eff_tos;
  logic [31:0]    tos_dec;
  logic           tos_le1;
  logic           found;
  logic [AW-1:0]  land_idx;
  logic [SPW-1:0] sp_m1;
  logic [AW-1:0]  top_idx;
  logic           rd_en;
  logic           wr_en;
  logic           done;

  // a landed level already holds its decremented count
  assign eff_tos = from_mem_r ? rd_r : tos_r;
  assign tos_dec = eff_tos - 32'd1;
  assign tos_le1 = (eff_tos[31:1] == 31'd0);
  assign sp_m1   = sp_r - SPW'(1);
  assign top_idx = sp_m1[AW-1:0];

  // highest level below the top whose saved count is above one
  always_comb begin
    found    = 1'b0;
    land_idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((i + 1) < int'(sp_r) && !one_r[i]) begin
        found    = 1'b1;
        land_idx = AW'(i);
      end
    end
  end

  always_comb begin
    tos_nxt      = tos_r;
    from_mem_nxt = from_mem_r;
    sp_nxt       = sp_r;
    one_nxt      = one_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    done         = 1'b0;
    if (sp_r == '0) begin
      done = 1'b1;
    end else if (!tos_le1) begin
      tos_nxt      = tos_dec;
      from_mem_nxt = 1'b0;
    end else if (found) begin
      sp_nxt       = SPW'(land_idx) + SPW'(1);
      from_mem_nxt = 1'b1;
      rd_en        = cmd.fin;
    end else begin
      sp_nxt = '0;
      done   = 1'b1;
    end
    if (!cmd.fin) begin
      tos_nxt      = tos_r;
      from_mem_nxt = from_mem_r;
      sp_nxt       = sp_r;
    end
    if (cmd.push) begin
      if (sp_r != '0) begin
        wr_en            = 1'b1;
        one_nxt[top_idx] = tos_le1;
      end
      tos_nxt      = cmd.count;
      from_mem_nxt = 1'b0;
      sp_nxt       = sp_r + SPW'(1);
    end
    if (cmd.clear) begin
      sp_nxt       = '0;
      from_mem_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r       <= '0;
      from_mem_r <= 1'b0;
      one_r      <= '0;
    end else begin
      sp_r       <= sp_nxt;
      from_mem_r <= from_mem_nxt;
      one_r      <= one_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
  end

  // count memory: saved count minus one, read when a pop lands on the level
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[top_idx] <= tos_dec;
    end
    if (rd_en) begin
      rd_r <= mem[land_idx];
    end
  end

  assign stat.done = done;
  assign stat.full = (sp_r >= SPW'(MAX_DEPTH));
  assign sp        = sp_r;

endmodule

`default_nettype wire

// ----- src/cbor_stream_tokenizer_core.sv -----
// cbor_stream_tokenizer_core: byte-wide cbor tokenizer top level
// depends on cbst_pkg and cbst_nest_stack
//
// usage
//   in channel: one stream byte per beat on in_data_byte (valid/ready)
//   out channel: one token per beat: kind, 64-bit value, nesting depth,
//     top-level item end flag and format error flag
//   a head with argument bytes gives its token on the beat of its last
//     argument byte; argument bytes before it give no token
// timing
//   one byte per cycle sustained while out_ready stays high; a token is valid in the cycle after the byte
//     that causes it is taken, held in the output register
//   the nesting counts live in a memory with a registered read; a pop
//     that lands on a lower level reads its count and the next byte uses the
//     registered read data directly, so the memory does not slow the stream
// reset
//   synchronous, active low: phase back to head, stack empty, output empty;
//     no memory clearing pass, levels are always written before they are read
// stall
//   when out_ready is low with a token waiting, in_ready drops and the
//   token and all state hold; a byte is taken in the cycle the token leaves
//   a format error gives its token and drops the stack back to the top level
`default_nettype none

module cbor_stream_tokenizer_core #(
  parameter int MAX_DEPTH = cbst_pkg::CBST_MAX_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [3:0]  out_token_kind,
  output      logic [63:0] out_token_value,
  output      logic [4:0]  out_nest_depth,
  output      logic        out_item_done,
  output      logic        out_format_error
);

  localparam int SPW = $clog2(MAX_DEPTH + 1);

  cbst_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [3:0]  arg_left_r, arg_left_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [30:0] pay_left_r, pay_left_nxt;

  logic        out_valid_r;
  logic [3:0]  kind_r;
  logic [63:0] value_r;
  logic [4:0]  depth_r;
  logic        done_r;
  logic        err_r;

  logic        fire;
  logic [2:0]  hd_major;
  logic [4:0]  hd_ai;

  // decode results
  logic        emit;
  logic [3:0]  tk_kind;
  logic [63:0] tk_value;
  logic        tk_err;
  logic        fin;
  logic        push;
  logic        clear;
  logic [31:0] push_count;

  // finished head argument
  logic        fa_go;
  logic [2:0]  fa_major;
  logic [63:0] fa_arg;
  logic        arg_big;
  logic        arg_zero;

  cbst_pkg::stk_cmd_t  stk_cmd;
  cbst_pkg::stk_stat_t stk_stat;
  logic [SPW-1:0]      sp;
  logic [SPW+4:0]      sp_wide;

  assign fire     = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign hd_major = in_data_byte[7:5];
  assign hd_ai    = in_data_byte[4:0];
  assign arg_big  = (fa_arg[63:31] != 33'd0);
  assign arg_zero = (fa_arg == 64'd0);

  always_comb begin
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    arg_left_nxt = arg_left_r;
    acc_nxt      = acc_r;
    pay_left_nxt = pay_left_r;
    emit         = 1'b0;
    tk_kind      = cbst_pkg::K_UINT;
    tk_value     = 64'd0;
    tk_err       = 1'b0;
    fin          = 1'b0;
    push         = 1'b0;
    clear        = 1'b0;
    push_count   = 32'd0;
    fa_go        = 1'b0;
    fa_major     = hd_major;
    fa_arg       = {59'd0, hd_ai};

    unique case (phase_r)
      cbst_pkg::PH_HEAD: begin
        if (in_data_byte == cbst_pkg::B_DOUBLE) begin
          phase_nxt    = cbst_pkg::PH_ARG;
          pend_nxt     = cbst_pkg::MAJ_SIMPLE;
          arg_left_nxt = 4'd8;
          acc_nxt      = 64'd0;
        end else if (hd_major == cbst_pkg::MAJ_TAG || hd_major == cbst_pkg::MAJ_SIMPLE) begin
          // tags and simple values are one byte long
          emit = 1'b1;
          fin  = 1'b1;
          case (in_data_byte)
            cbst_pkg::B_FALSE: tk_kind = cbst_pkg::K_FALSE;
            cbst_pkg::B_TRUE:  tk_kind = cbst_pkg::K_TRUE;
            cbst_pkg::B_NULL:  tk_kind = cbst_pkg::K_NULL;
            default: begin
              tk_kind  = cbst_pkg::K_UNSUP;
              tk_value = {56'd0, in_data_byte};
            end
          endcase
        end else if (hd_ai < cbst_pkg::AI_ONE_BYTE) begin
          fa_go = 1'b1;
        end else if (hd_ai < cbst_pkg::AI_RESERVED) begin
          phase_nxt    = cbst_pkg::PH_ARG;
          pend_nxt     = hd_major;
          arg_left_nxt = 4'd1 << hd_ai[1:0];
          acc_nxt      = 64'd0;
        end else if (hd_major == cbst_pkg::MAJ_UINT || hd_major == cbst_pkg::MAJ_NINT) begin
          emit     = 1'b1;
          fin      = 1'b1;
          tk_kind  = cbst_pkg::K_UNSUP;
          tk_value = {56'd0, in_data_byte};
        end else begin
          // indefinite or reserved length on a sized type
          emit    = 1'b1;
          tk_kind = {1'b0, hd_major};
          tk_err  = 1'b1;
          clear   = 1'b1;
        end
      end
      cbst_pkg::PH_ARG: begin
        acc_nxt = {acc_r[55:0], in_data_byte};
        if (arg_left_r > 4'd1) begin
          arg_left_nxt = arg_left_r - 4'd1;
        end else begin
          arg_left_nxt = 4'd0;
          fa_go        = 1'b1;
          fa_major     = pend_r;
          fa_arg       = {acc_r[55:0], in_data_byte};
        end
      end
      cbst_pkg::PH_PAYLOAD: begin
        emit     = 1'b1;
        tk_kind  = cbst_pkg::K_PAYLOAD;
        tk_value = {56'd0, in_data_byte};
        if (pay_left_r > 31'd1) begin
          pay_left_nxt = pay_left_r - 31'd1;
        end else begin
          pay_left_nxt = 31'd0;
          phase_nxt    = cbst_pkg::PH_HEAD;
          fin          = 1'b1;
        end
      end
      default: begin
        phase_nxt = cbst_pkg::PH_HEAD;
      end
    endcase

    // head complete: act on its argument
    if (fa_go) begin
      phase_nxt = cbst_pkg::PH_HEAD;
      emit      = 1'b1;
      tk_kind   = {1'b0, fa_major};
      tk_value  = fa_arg;
      case (fa_major) inside
        cbst_pkg::MAJ_UINT, cbst_pkg::MAJ_NINT: begin
          fin = 1'b1;
        end
        cbst_pkg::MAJ_BYTES, cbst_pkg::MAJ_TEXT: begin
          if (arg_big) begin
            tk_err = 1'b1;
            clear  = 1'b1;
          end else if (arg_zero) begin
            fin = 1'b1;
          end else begin
            phase_nxt    = cbst_pkg::PH_PAYLOAD;
            pay_left_nxt = fa_arg[30:0];
          end
        end
        cbst_pkg::MAJ_ARRAY, cbst_pkg::MAJ_MAP: begin
          if (arg_big) begin
            tk_err = 1'b1;
            clear  = 1'b1;
          end else if (arg_zero) begin
            fin = 1'b1;
          end else if (stk_stat.full) begin
            tk_err = 1'b1;
            clear  = 1'b1;
          end else begin
            push = 1'b1;
            // a map entry is a key and a value
            push_count = (fa_major == cbst_pkg::MAJ_MAP) ? {fa_arg[30:0], 1'b0}
                                                          : fa_arg[31:0];
          end
        end
        default: begin
          tk_kind = cbst_pkg::K_DOUBLE;
          fin     = 1'b1;
        end
      endcase
    end

    // back to idle after a format error
    if (clear) begin
      phase_nxt    = cbst_pkg::PH_HEAD;
      pend_nxt     = 3'd0;
      arg_left_nxt = 4'd0;
      acc_nxt      = 64'd0;
      pay_left_nxt = 31'd0;
    end
  end

  assign stk_cmd.fin   = fire && fin;
  assign stk_cmd.push  = fire && push;
  assign stk_cmd.clear = fire && clear;
  assign stk_cmd.count = push_count;

  cbst_nest_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .SPW       (SPW)
  ) u_nest_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat),
    .sp    (sp)
  );

  assign sp_wide = {5'd0, sp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= cbst_pkg::PH_HEAD;
      pend_r     <= 3'd0;
      arg_left_r <= 4'd0;
      acc_r      <= 64'd0;
      pay_left_r <= 31'd0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      pend_r     <= pend_nxt;
      arg_left_r <= arg_left_nxt;
      acc_r      <= acc_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r  <= tk_kind;
      value_r <= tk_value;
      depth_r <= sp_wide[4:0];
      done_r  <= fin && stk_stat.done;
      err_r   <= tk_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = kind_r;
  assign out_token_value  = value_r;
  assign out_nest_depth   = depth_r;
  assign out_item_done    = done_r;
  assign out_format_error = err_r;

endmodule

`default_nettype wire

// ----- src/cbst_port_checker.sv -----
// cbst_port_checker: port-level assertions of the cbor stream tokenizer
// bound to cbor_stream_tokenizer_core; depends on cbst_pkg
`default_nettype none

module cbst_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_token_kind,
  input wire logic [63:0] out_token_value,
  input wire logic [4:0]  out_nest_depth,
  input wire logic        out_item_done,
  input wire logic        out_format_error
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind)
      && $stable(out_token_value) && $stable(out_nest_depth)
      && $stable(out_item_done) && $stable(out_format_error))
    else $error("token changed while stalled");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an error token never closes an item
  a_err_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format_error |-> !out_item_done)
    else $error("error token marked item done");

  // payload tokens carry one byte
  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == cbst_pkg::K_PAYLOAD |-> out_token_value[63:8] == 56'd0)
    else $error("payload token wider than a byte");

  // errors only on sized heads
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format_error |->
      out_token_kind == cbst_pkg::K_BYTES || out_token_kind == cbst_pkg::K_TEXT
      || out_token_kind == cbst_pkg::K_ARRAY || out_token_kind == cbst_pkg::K_MAP)
    else $error("error flagged on a kind that cannot fail");

endmodule

bind cbor_stream_tokenizer_core cbst_port_checker u_port_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_token_value  (out_token_value),
  .out_nest_depth   (out_nest_depth),
  .out_item_done    (out_item_done),
  .out_format_error (out_format_error)
);

`default_nettype wire

// ----- test/tb_cbor_stream_tokenizer_core.sv -----
`timescale 1ns / 1ps
// tb_cbor_stream_tokenizer_core: self-checking bench for the cbor stream tokenizer
// depends on cbst_pkg and cbor_stream_tokenizer_core; carries its own token predictor

module tb_cbor_stream_tokenizer_core;

  localparam int CLK_PERIOD     = 4;
  localparam int DEPTH          = cbst_pkg::CBST_MAX_DEPTH;
  localparam int PHASE_BYTES    = 525;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_GAP      = 8;
  localparam int END_WAIT       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] LEN_MAX = 64'h7FFF_FFFF;

  // one token as it leaves the block
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [4:0]  depth;
    logic        done;
    logic        err;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [63:0] out_token_value;
  logic [4:0]  out_nest_depth;
  logic        out_item_done;
  logic        out_format_error;

  cbor_stream_tokenizer_core #(
    .MAX_DEPTH(DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_nest_depth  (out_nest_depth),
    .out_item_done   (out_item_done),
    .out_format_error(out_format_error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ------------------------------------------------------------------
  // token predictor: mirrors the decoder state in bench-side variables
  // ------------------------------------------------------------------
  cbst_pkg::phase_t dec_phase;
  logic [2:0]  dec_major;
  int unsigned dec_arg_left;
  logic [63:0] dec_acc;
  logic [31:0] dec_pay_left;
  logic [31:0] dec_level [DEPTH];
  int unsigned dec_sp;

  // drop back to the top level waiting for a head, as after reset or an error
  function automatic void dec_clear();
    dec_phase    = cbst_pkg::PH_HEAD;
    dec_major    = '0;
    dec_arg_left = 0;
    dec_acc      = '0;
    dec_pay_left = '0;
    foreach (dec_level[i]) dec_level[i] = '0;
    dec_sp       = 0;
  endfunction

  // one item at the current level is complete; pop every level that runs dry
  // returns 1 when the pops reach the top level, i.e. a top-level item ended
  function automatic logic close_item();
    while (dec_sp != 0) begin
      if (dec_level[dec_sp - 1] > 1) begin
        dec_level[dec_sp - 1]--;
        return 1'b0;
      end
      dec_level[dec_sp - 1] = '0;
      dec_sp--;
    end
    return 1'b1;
  endfunction

  function automatic token_t make_tok(logic [3:0] kind, logic [63:0] value, logic [4:0] depth,
                                     logic done, logic err);
    return '{kind, value, depth, done, err};
  endfunction

  // a head whose argument is complete; kinds 0..5 follow the major type order
  function automatic token_t finish_head(logic [2:0] major, logic [63:0] arg);
    logic [4:0] depth;
    logic [3:0] kind;
    token_t     tok;
    depth     = 5'(dec_sp);
    kind      = {1'b0, major};
    dec_phase = cbst_pkg::PH_HEAD;
    if (major == cbst_pkg::MAJ_UINT || major == cbst_pkg::MAJ_NINT) begin
      tok = make_tok(kind, arg, depth, close_item(), 1'b0);
    end else if (major == cbst_pkg::MAJ_SIMPLE) begin
      tok = make_tok(cbst_pkg::K_DOUBLE, arg, depth, close_item(), 1'b0);
    end else if (arg > LEN_MAX
                 || (major >= cbst_pkg::MAJ_ARRAY && arg != 0 && dec_sp >= DEPTH)) begin
      // oversize length or no room for one more level
      tok = make_tok(kind, arg, depth, 1'b0, 1'b1);
      dec_clear();
    end else if (arg == 0) begin
      // empty string or container is a whole item by itself
      tok = make_tok(kind, '0, depth, close_item(), 1'b0);
    end else if (major <= cbst_pkg::MAJ_TEXT) begin
      dec_phase    = cbst_pkg::PH_PAYLOAD;
      dec_pay_left = arg[31:0];
      tok = make_tok(kind, arg, depth, 1'b0, 1'b0);
    end else begin
      // a map counts key and value separately
      dec_level[dec_sp] = (major == cbst_pkg::MAJ_MAP) ? {arg[30:0], 1'b0} : arg[31:0];
      dec_sp++;
      tok = make_tok(kind, arg, depth, 1'b0, 1'b0);
    end
    return tok;
  endfunction

  // feed one stream byte; returns 1 and the token when the byte yields one
  function automatic logic tokenize_byte(logic [7:0] b, output token_t tok);
    logic [2:0]  major;
    logic [4:0]  ai;
    logic [4:0]  depth;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        done;
    major = b[7:5];
    ai    = b[4:0];
    depth = 5'(dec_sp);
    if (dec_phase == cbst_pkg::PH_ARG) begin
      dec_acc = {dec_acc[55:0], b};
      if (dec_arg_left > 1) begin
        dec_arg_left--;
        return 1'b0;
      end
      dec_arg_left = 0;
      tok = finish_head(dec_major, dec_acc);
      return 1'b1;
    end
    if (dec_phase == cbst_pkg::PH_PAYLOAD) begin
      done = 1'b0;
      if (dec_pay_left > 1) begin
        dec_pay_left--;
      end else begin
        dec_pay_left = '0;
        dec_phase    = cbst_pkg::PH_HEAD;
        done         = close_item();
      end
      tok = make_tok(cbst_pkg::K_PAYLOAD, {56'h0, b}, depth, done, 1'b0);
      return 1'b1;
    end
    if (b == cbst_pkg::B_DOUBLE) begin
      dec_phase    = cbst_pkg::PH_ARG;
      dec_major    = cbst_pkg::MAJ_SIMPLE;
      dec_arg_left = 8;
      dec_acc      = '0;
      return 1'b0;
    end
    if (major >= cbst_pkg::MAJ_TAG) begin
      // tags and simple values stand alone; only false, true and null are known
      kind  = cbst_pkg::K_UNSUP;
      value = {56'h0, b};
      if (b == cbst_pkg::B_FALSE) begin
        kind  = cbst_pkg::K_FALSE;
        value = '0;
      end else if (b == cbst_pkg::B_TRUE) begin
        kind  = cbst_pkg::K_TRUE;
        value = '0;
      end else if (b == cbst_pkg::B_NULL) begin
        kind  = cbst_pkg::K_NULL;
        value = '0;
      end
      tok = make_tok(kind, value, depth, close_item(), 1'b0);
      return 1'b1;
    end
    if (ai < cbst_pkg::AI_ONE_BYTE) begin
      tok = finish_head(major, {59'h0, ai});
      return 1'b1;
    end
    if (ai < cbst_pkg::AI_RESERVED) begin
      dec_phase    = cbst_pkg::PH_ARG;
      dec_major    = major;
      dec_arg_left = 1 << (ai - cbst_pkg::AI_ONE_BYTE);
      dec_acc      = '0;
      return 1'b0;
    end
    if (major <= cbst_pkg::MAJ_NINT) begin
      // reserved or indefinite integer: flagged unsupported, not an error
      tok = make_tok(cbst_pkg::K_UNSUP, {56'h0, b}, depth, close_item(), 1'b0);
      return 1'b1;
    end
    // reserved or indefinite length on a sized type
    tok = make_tok({1'b0, major}, '0, depth, 1'b0, 1'b1);
    dec_clear();
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // stream generation: every unit ends on a head boundary, so the stream
  // never falls into a long payload the bench did not plan
  // ------------------------------------------------------------------
  logic [7:0] stream_bytes [$];
  token_t     expected_tokens [$];

  task automatic put_byte(logic [7:0] b);
    stream_bytes.push_back(b);
  endtask

  // argument values biased toward encoding edges
  function automatic logic [63:0] rand_arg();
    case ($urandom_range(7))
      0, 1: return 64'($urandom_range(23));
      2:    return 64'($urandom_range(255));
      3:    return 64'($urandom_range(65535));
      4:    return {32'h0, $urandom};
      5:    return {$urandom, $urandom};
      6:    return '1;
      default: begin
        case ($urandom_range(6))
          0: return 64'd24;
          1: return 64'd256;
          2: return 64'hFFFF;
          3: return 64'h1_0000;
          4: return 64'hFFFF_FFFF;
          5: return 64'h1_0000_0000;
          default: return 64'h8000_0000_0000_0000;
        endcase
      end
    endcase
  endfunction

  // head with its argument; sometimes in a wider form than needed
  task automatic put_head(logic [2:0] major, logic [63:0] arg);
    int lowest;
    int width_code;
    if (arg < 24) lowest = 0;
    else if (arg < 64'h100) lowest = 1;
    else if (arg < 64'h1_0000) lowest = 2;
    else if (arg < 64'h1_0000_0000) lowest = 3;
    else lowest = 4;
    width_code = ($urandom_range(3) == 0) ? $urandom_range(4, lowest) : lowest;
    if (width_code == 0) begin
      put_byte({major, arg[4:0]});
    end else begin
      put_byte({major, cbst_pkg::AI_ONE_BYTE + 5'(width_code - 1)});
      for (int i = (1 << (width_code - 1)) - 1; i >= 0; i--) put_byte(arg[i*8 +: 8]);
    end
  endtask

  // one well-formed item; depth is where the bench believes it stands
  task automatic gen_item(int depth);
    int          pick;
    int          count;
    logic [2:0]  major;
    logic [7:0]  hb;
    logic [63:0] bits;
    pick = $urandom_range(99);
    if (pick < 18) begin
      major = $urandom_range(1) ? cbst_pkg::MAJ_NINT : cbst_pkg::MAJ_UINT;
      put_head(major, rand_arg());
    end else if (pick < 34) begin
      major = $urandom_range(1) ? cbst_pkg::MAJ_TEXT : cbst_pkg::MAJ_BYTES;
      count = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      put_head(major, 64'(count));
      repeat (count) put_byte(8'($urandom));
    end else if (pick < 56) begin
      // deep down only empty containers, so nothing overflows by accident
      major = $urandom_range(1) ? cbst_pkg::MAJ_MAP : cbst_pkg::MAJ_ARRAY;
      count = (depth < 4) ? $urandom_range(3) : 0;
      put_head(major, 64'(count));
      repeat ((major == cbst_pkg::MAJ_MAP) ? 2 * count : count) gen_item(depth + 1);
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0: put_byte(cbst_pkg::B_FALSE);
        1: put_byte(cbst_pkg::B_TRUE);
        2: put_byte(cbst_pkg::B_NULL);
        3: begin
          bits = rand_arg();
          put_byte(cbst_pkg::B_DOUBLE);
          for (int i = 7; i >= 0; i--) put_byte(bits[i*8 +: 8]);
        end
        default: begin
          // any tag or simple value byte but the double head
          hb = 8'hC0 | 8'($urandom_range(63));
          if (hb == cbst_pkg::B_DOUBLE) hb = 8'hFF;
          put_byte(hb);
        end
      endcase
    end else if (pick < 86) begin
      major = $urandom_range(1) ? cbst_pkg::MAJ_NINT : cbst_pkg::MAJ_UINT;
      put_byte({major, cbst_pkg::AI_RESERVED + 5'($urandom_range(3))});
    end else if (pick < 91 && depth == 0) begin
      // chain of one-element arrays, up to every level in use
      count = $urandom_range(DEPTH);
      repeat (count) put_head(cbst_pkg::MAJ_ARRAY, 64'd1);
      gen_item(count);
    end else begin
      put_byte({cbst_pkg::MAJ_UINT, 5'($urandom_range(23))});
    end
  endtask

  // a few open levels left unfinished, then a head the block must reject
  task automatic gen_broken();
    int          opened;
    logic [2:0]  major;
    logic [63:0] count;
    opened = $urandom_range(2);
    for (int k = 0; k < opened; k++) begin
      major = $urandom_range(1) ? cbst_pkg::MAJ_MAP : cbst_pkg::MAJ_ARRAY;
      count = ($urandom_range(3) == 0) ? LEN_MAX : 64'($urandom_range(6, 2));
      put_head(major, count);
      gen_item(k + 1);
    end
    major = 3'($urandom_range(cbst_pkg::MAJ_MAP, cbst_pkg::MAJ_BYTES));
    case ($urandom_range(2))
      0: put_byte({major, cbst_pkg::AI_RESERVED + 5'($urandom_range(3))});
      1: begin
        case ($urandom_range(3))
          0: count = LEN_MAX + 1;
          1: count = {32'h0, $urandom | 32'h8000_0000};
          2: count = {$urandom | 32'h1, $urandom};
          default: count = '1;
        endcase
        put_head(major, count);
      end
      default: begin
        // fill every level, then ask for one more
        for (int k = opened; k < DEPTH; k++) begin
          if ($urandom_range(1)) put_head(cbst_pkg::MAJ_MAP, 64'($urandom_range(2, 1)));
          else put_head(cbst_pkg::MAJ_ARRAY, 64'($urandom_range(3, 2)));
        end
        if ($urandom_range(1)) gen_item(DEPTH);
        put_head($urandom_range(1) ? cbst_pkg::MAJ_MAP : cbst_pkg::MAJ_ARRAY,
                 64'($urandom_range(3, 1)));
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // sender: offers the oldest pending byte, holds it until taken
  // ------------------------------------------------------------------
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) stream_bytes.delete(0);
      if (!in_valid || in_ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_bytes[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: random stalls plus a long hold-off on request
  // ------------------------------------------------------------------
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------
  // monitor: checks each token beat, predicts from each byte beat
  // ------------------------------------------------------------------
  int          mismatches = 0;
  int          bytes_in = 0;
  int          tokens_out = 0;
  int          items_closed = 0;
  int          error_tokens = 0;
  int          deepest = 0;
  logic [11:0] kinds_seen = '0;

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    token_t want;
    token_t next_tok;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tokens_out++;
        if (out_item_done) items_closed++;
        if (out_format_error) error_tokens++;
        if (out_token_kind <= cbst_pkg::K_UNSUP) kinds_seen[out_token_kind] = 1'b1;
        if (out_nest_depth > deepest) deepest = out_nest_depth;
        if (expected_tokens.size() == 0) begin
          $error("token beat with nothing expected: kind %0d value %0h",
                 out_token_kind, out_token_value);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", 64'(want.kind), 64'(out_token_kind));
          check_field("token_value", want.value, out_token_value);
          check_field("nest_depth", 64'(want.depth), 64'(out_nest_depth));
          check_field("item_done", 64'(want.done), 64'(out_item_done));
          check_field("format_error", 64'(want.err), 64'(out_format_error));
        end
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        if (tokenize_byte(in_data_byte, next_tok)) expected_tokens.push_back(next_tok);
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog: too long without any beat on either side ends the run
  // ------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes pending, %0d tokens owed",
               quiet_cycles, stream_bytes.size(), expected_tokens.size());
      $display("tb_cbor_stream_tokenizer_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // sequence: directed bytes, then three random passes with different stalls
  // ------------------------------------------------------------------

  // wait until every byte is in and every token is out
  task automatic drain();
    while (stream_bytes.size() != 0 || expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  // extremes, every token kind but the double, and two reject paths in a short stream
  localparam logic [7:0] DIRECTED [25] = '{
    8'h00, 8'h37,                    // smallest uint, largest inline negint
    cbst_pkg::B_FALSE, cbst_pkg::B_TRUE, cbst_pkg::B_NULL,
    8'hC1, 8'hFF,                    // tag and break byte: unsupported
    8'h1C,                           // reserved info on an integer
    8'h40, 8'h80, 8'hA0,             // empty string, array, map
    8'h62, 8'h61, 8'h62,             // two-byte text
    8'h82, 8'h01, 8'hA1, 8'h00, cbst_pkg::B_NULL,  // [1, {0: null}]
    8'h5F,                           // indefinite byte string: rejected
    8'h9A, 8'h80, 8'h00, 8'h00, 8'h00    // array count just past the limit
  };

  int send_pct_by_pass [3] = '{34, 53, 0};
  int recv_pct_by_pass [3] = '{53, 34, 0};

  initial begin
    dec_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = send_pct_by_pass[0];
    recv_idle_pct = recv_pct_by_pass[0];
    foreach (DIRECTED[i]) put_byte(DIRECTED[i]);
    drain();

    for (int pass = 0; pass < 3; pass++) begin
      send_idle_pct = send_pct_by_pass[pass];
      recv_idle_pct = recv_pct_by_pass[pass];
      // with no idling the sender keeps offering while the receiver sits
      // out a long stretch, so the output register fills and input stalls
      if (pass == 2) hold_requests++;
      while (stream_bytes.size() < PHASE_BYTES) begin
        if ($urandom_range(99) < 85) gen_item(0);
        else gen_broken();
      end
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    @(negedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      mismatches++;
    end

    $display("run covered %0d stream bytes and %0d tokens: %0d top-level items, %0d rejects",
             bytes_in, tokens_out, items_closed, error_tokens);
    $display("token kinds seen %b, deepest level %0d, receiver hold-off of %0d cycles",
             kinds_seen, deepest, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_cbor_stream_tokenizer_core: done, clean");
    end else begin
      $display("tb_cbor_stream_tokenizer_core: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cbst_pkg.sv
src/cbst_nest_stack.sv
src/cbor_stream_tokenizer_core.sv
src/cbst_port_checker.sv
test/tb_cbor_stream_tokenizer_core.sv
